/* design/prfc_pkg.sv */
// shared types and constants for the playout ring fill controller
`default_nettype none

package prfc_pkg;

   localparam int unsigned CsrAddrWidth = 5;

   typedef enum logic [2:0] {
      REG_RING_BYTES  = 3'd0,
      REG_FRAME_BYTES = 3'd1,
      REG_LOW_LEVEL   = 3'd2,
      REG_SAFE_LEVEL  = 3'd3,
      REG_RELAX_MS    = 3'd4
   } reg_index_type;

   localparam logic [15:0] RingBytesReset  = 16'd4160;
   localparam logic [15:0] FrameBytesReset = 16'd320;
   localparam logic [15:0] LowLevelReset   = 16'd1280;
   localparam logic [15:0] SafeLevelReset  = 16'd1280;
   localparam logic [15:0] RelaxMsReset    = 16'd4000;

   localparam logic [15:0] MinRingBytes = 16'd2;

   typedef struct packed {
      logic [15:0] ring_bytes;
      logic [15:0] frame_bytes;
      logic [15:0] low_level;
      logic [15:0] safe_level;
      logic [15:0] relax_ms;
   } cfg_type;

   typedef struct packed {
      logic [31:0] now_ms;
      logic [15:0] write_cursor;
      logic [15:0] play_cursor;
   } poll_type;

   typedef struct packed {
      logic [15:0] target_level;
      logic [15:0] queued_ahead;
      logic [15:0] fill_offset;
      logic        fill_now;
   } result_type;

endpackage

`default_nettype wire

/* design/prfc_csr.sv */
// apb register file holding the ring, frame, level and relax settings
`default_nettype none

module prfc_csr
   import prfc_pkg::*;
(
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    csr_psel,
   input  wire logic                    csr_penable,
   input  wire logic                    csr_pwrite,
   input  wire logic [CsrAddrWidth-1:0] csr_paddr,
   input  wire logic [31:0]             csr_pwdata,
   output logic      [31:0]             csr_prdata,
   output logic                         csr_pready,
   output cfg_type                      cfg
);

   cfg_type       cfg_ff;
   cfg_type       cfg_in;
   reg_index_type idx;
   logic          wr_en;

   assign idx        = reg_index_type'(csr_paddr[CsrAddrWidth-1:2]);
   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (idx)
            REG_RING_BYTES:  cfg_in.ring_bytes  = csr_pwdata[15:0];
            REG_FRAME_BYTES: cfg_in.frame_bytes = csr_pwdata[15:0];
            REG_LOW_LEVEL:   cfg_in.low_level   = csr_pwdata[15:0];
            REG_SAFE_LEVEL:  cfg_in.safe_level  = csr_pwdata[15:0];
            REG_RELAX_MS:    cfg_in.relax_ms    = csr_pwdata[15:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.ring_bytes  <= RingBytesReset;
         cfg_ff.frame_bytes <= FrameBytesReset;
         cfg_ff.low_level   <= LowLevelReset;
         cfg_ff.safe_level  <= SafeLevelReset;
         cfg_ff.relax_ms    <= RelaxMsReset;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      case (idx)
         REG_RING_BYTES:  csr_prdata = {16'd0, cfg_ff.ring_bytes};
         REG_FRAME_BYTES: csr_prdata = {16'd0, cfg_ff.frame_bytes};
         REG_LOW_LEVEL:   csr_prdata = {16'd0, cfg_ff.low_level};
         REG_SAFE_LEVEL:  csr_prdata = {16'd0, cfg_ff.safe_level};
         REG_RELAX_MS:    csr_prdata = {16'd0, cfg_ff.relax_ms};
         default:         csr_prdata = 32'd0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

/* design/prfc_core.sv */
// one-pass poll evaluation with the offset, target and last-low state
`default_nettype none

module prfc_core
   import prfc_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire cfg_type    cfg,
   input  wire logic       step,
   input  wire poll_type   poll,
   output result_type      result
);

   logic [15:0] next_offset_ff, next_offset_in;
   logic [15:0] fill_target_ff, fill_target_in;
   logic [31:0] last_low_ms_ff, last_low_ms_in;

   logic [15:0] ring, play, wr, offs, queued, cap, shrunk, qa;
   logic [16:0] queued_sum, qa_sum, grown, adv, adv_wrap;
   logic [31:0] quiet;
   logic        is_low, grow, shrink, fill;

   always_comb begin
      ring = (cfg.ring_bytes < MinRingBytes) ? MinRingBytes : cfg.ring_bytes;
      play = (poll.play_cursor  >= ring) ? ring - 16'd1 : poll.play_cursor;
      wr   = (poll.write_cursor >= ring) ? ring - 16'd1 : poll.write_cursor;
      offs = (next_offset_ff >= ring) ? 16'd0 : next_offset_ff;

      // distance around the ring from the write cursor to the offset
      queued_sum = (offs >= wr) ? {1'b0, offs} - {1'b0, wr}
                                : {1'b0, offs} + {1'b0, ring} - {1'b0, wr};
      queued     = queued_sum[15:0];

      is_low = queued <= cfg.low_level;
      grow   = is_low && (queued < cfg.safe_level);
      quiet  = poll.now_ms - last_low_ms_ff;
      shrink = !is_low && (quiet > {16'd0, cfg.relax_ms});

      cap    = (ring > cfg.frame_bytes) ? ring - cfg.frame_bytes : 16'd0;
      grown  = {1'b0, fill_target_ff} + {1'b0, cfg.frame_bytes};
      shrunk = (fill_target_ff > cfg.frame_bytes) ? fill_target_ff - cfg.frame_bytes
                                                  : 16'd0;

      priority if (grow) begin
         fill_target_in = (grown < {1'b0, cap}) ? grown[15:0] : cap;
      end else if (shrink) begin
         fill_target_in = (shrunk > cfg.low_level) ? shrunk : cfg.low_level;
      end else begin
         fill_target_in = fill_target_ff;
      end

      last_low_ms_in = (is_low || shrink) ? poll.now_ms : last_low_ms_ff;

      fill = queued <= fill_target_in;

      qa_sum = (offs >= play) ? {1'b0, offs} - {1'b0, play}
                              : {1'b0, offs} + {1'b0, ring} - {1'b0, play};
      qa     = qa_sum[15:0];

      // advance by one frame with wrap, falling back to zero for oversized frames
      adv      = {1'b0, offs} + {1'b0, cfg.frame_bytes};
      adv_wrap = (adv >= {1'b0, ring}) ? adv - {1'b0, ring} : adv;
      next_offset_in = fill ? ((adv_wrap >= {1'b0, ring}) ? 16'd0 : adv_wrap[15:0])
                            : offs;

      result.fill_now     = fill;
      result.fill_offset  = fill ? offs : 16'd0;
      result.queued_ahead = fill ? qa : 16'd0;
      result.target_level = fill_target_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         next_offset_ff <= FrameBytesReset;
         fill_target_ff <= LowLevelReset;
         last_low_ms_ff <= 32'd0;
      end else if (step) begin
         next_offset_ff <= next_offset_in;
         fill_target_ff <= fill_target_in;
         last_low_ms_ff <= last_low_ms_in;
      end
   end

endmodule

`default_nettype wire

/* design/playout_ring_fill_control_core.sv */
// top level of the playout ring fill controller
//
// usage:
//   req_ channel: one beat per device poll; tdata carries play_cursor,
//   write_cursor and now_ms. each poll gives exactly one beat on rsp_.
//   rsp_ channel: tuser is fill_now; tdata carries fill_offset,
//   queued_ahead and target_level. when fill_now is 1 the host writes one
//   frame at fill_offset.
//   csr_ port: apb registers at byte addresses 0x00 ring_bytes,
//   0x04 frame_bytes, 0x08 low_level, 0x0c safe_level, 0x10 relax_ms;
//   write them only while no poll is in flight.
// timing:
//   a poll beat lands in an input register, is evaluated in one pass and
//   lands in the result register, which drives the rsp_ channel.
//   one poll per cycle is sustained while rsp_tready stays high; the
//   state loop (offset, target, last-low time) closes within one evaluation.
// reset: settings return to their defaults, offset to one frame, target to
//   the low level, last-low time to zero; both channels empty.
// stall: when rsp_tready is low the result holds and one more poll can
//   wait in the input register; req_tready drops after that.
`default_nettype none

module playout_ring_fill_control_core
   import prfc_pkg::*;
(
   input  wire logic                    clock,
   input  wire logic                    reset,
   // req_tdata: play_cursor[15:0], write_cursor[31:16], now_ms[63:32]
   input  wire logic                    req_tvalid,
   output logic                         req_tready,
   input  wire logic [63:0]             req_tdata,
   // rsp_tdata: fill_offset[15:0], queued_ahead[31:16], target_level[47:32]
   // rsp_tuser: fill_now[0]
   output logic                         rsp_tvalid,
   input  wire logic                    rsp_tready,
   output logic      [47:0]             rsp_tdata,
   output logic      [0:0]              rsp_tuser,
   input  wire logic                    csr_psel,
   input  wire logic                    csr_penable,
   input  wire logic                    csr_pwrite,
   input  wire logic [CsrAddrWidth-1:0] csr_paddr,
   input  wire logic [31:0]             csr_pwdata,
   output logic      [31:0]             csr_prdata,
   output logic                         csr_pready
);

   cfg_type    cfg;
   poll_type   poll_ff;
   logic       poll_valid_ff;
   result_type result;
   result_type result_ff;
   logic       rsp_valid_ff;
   logic       step;

   prfc_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // evaluate when the result register is free or being emptied
   assign step       = poll_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !poll_valid_ff || step;

   prfc_core u_core (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg),
      .step   (step),
      .poll   (poll_ff),
      .result (result)
   );

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         poll_valid_ff <= 1'b0;
      end else if (req_tready) begin
         poll_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         poll_ff <= poll_type'(req_tdata);
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (step) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         result_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = result_ff.fill_now;
   assign rsp_tdata  = {result_ff.target_level, result_ff.queued_ahead,
                        result_ff.fill_offset};

endmodule

`default_nettype wire
